// ----- hw/rtl/rcfp_pkg.sv -----
// Shared constants and types of the RC channel frame packer.
package rcfp_pkg;

  localparam int unsigned ChannelCount = 18;
  localparam int unsigned WideChannels = 16;
  localparam int unsigned HeaderBytes  = 3;
  localparam int unsigned MaxResults   = 4;

  // Channel word: v*5/6 + 1024, clamped to 1..2047.
  localparam int unsigned WordWidth    = 11;
  localparam int          WordCenter   = 1024;
  localparam int          WordMin      = 1;
  localparam int          WordMax      = 2047;
  // Switch bit: v + 1024 >= 1536, i.e. v >= 512.
  localparam int          SwitchLevel  = 1536 - WordCenter;

  // floor(x/6) = (x * ceil(2^17/6)) >> 17 for 0 <= x < 32768.
  localparam int unsigned RecipShift   = 17;
  localparam int unsigned RecipWidth   = 15;
  localparam int unsigned RecipSix     = ((1 << RecipShift) + 5) / 6;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    RegSyncOne    = 2'd0,
    RegSyncTwo    = 2'd1,
    RegFrameMark  = 2'd2
  } reg_idx_e;

endpackage

// ----- hw/rtl/rc_channel_frame_packer_top.sv -----
// Top level of the RC channel frame packer: input register, packing logic, byte serializer.
//
// Takes 18 channel requests per frame (channels 0..15 become clamped 11-bit words,
// 16 and 17 become switch bits) and streams the frame on the output channel one byte per
// cycle while out_ready_i is high: three header bytes ahead of channel 0, then 23 payload
// bytes packed LSB first, the last one zero padded and flagged by last_byte_o. A request
// is captured in an input register; combinational logic scales, clamps and packs it and
// loads up to four bytes into the output buffer, which then drains one byte per cycle
// while out_ready_i is high. Most channels give one or two bytes, channel 0 gives four
// and channel 16 none, and the drain rate of the output buffer sets the pace. The input
// register lets a new request in while the buffer still holds bytes. Header bytes come
// from the three configuration registers (index 0, 1, 2; other indexes ignored), which
// reset to zero; cfg_ready_o is always high. Write them only while the block is idle.
module rc_channel_frame_packer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  // channel requests
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [11:0] channel_value_i,
  input  logic signed [9:0]  center_offset_i,
  // frame bytes
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         frame_byte_o,
  output logic               last_byte_o
);

  // Configuration registers.
  logic [7:0] sync_one_q, sync_two_q, marker_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_one_q <= '0;
      sync_two_q <= '0;
      marker_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (rcfp_pkg::reg_idx_e'(cfg_index_i))
        rcfp_pkg::RegSyncOne:   sync_one_q <= cfg_data_i;
        rcfp_pkg::RegSyncTwo:   sync_two_q <= cfg_data_i;
        rcfp_pkg::RegFrameMark: marker_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  logic               in_full_q;
  logic signed [11:0] value_q;
  logic signed [9:0]  offset_q;

  // Output buffer: up to four bytes, drained from slot 0.
  logic [7:0] buf_q [rcfp_pkg::MaxResults];
  logic [7:0] buf_d [rcfp_pkg::MaxResults];
  logic [2:0] rem_q, rem_d;
  logic       last_q, last_d;

  // Frame state.
  logic [4:0] chan_q, chan_d;
  logic [6:0] pend_bits_q, pend_bits_d;
  logic [2:0] pend_cnt_q, pend_cnt_d;

  logic out_fire, buf_free, load;

  assign out_valid_o  = (rem_q != 3'd0);
  assign out_fire     = out_valid_o && out_ready_i;
  assign buf_free     = (rem_q == 3'd0) || ((rem_q == 3'd1) && out_ready_i);
  assign load         = in_full_q && buf_free;
  assign in_ready_o   = !in_full_q || load;
  assign frame_byte_o = buf_q[0];
  assign last_byte_o  = last_q && (rem_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_ready_o) begin
      in_full_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      value_q  <= channel_value_i;
      offset_q <= center_offset_i;
    end
  end

  // ---- Channel scaling ----
  logic signed [12:0] lvl;          // value + 2*offset
  logic [11:0]        lvl_abs;
  logic [13:0]        mag5;
  logic [28:0]        prod;
  logic [11:0]        quo;
  logic signed [12:0] scaled;
  logic signed [12:0] sum;
  logic [10:0]        word;
  logic               sw_bit;

  always_comb begin
    lvl     = {value_q[11], value_q} + {offset_q[9], offset_q[9], offset_q, 1'b0};
    lvl_abs = lvl[12] ? 12'(-lvl) : 12'(lvl);
    mag5    = {lvl_abs, 2'b00} + {2'b00, lvl_abs};
    prod    = 29'(mag5) * 29'(rcfp_pkg::RecipSix[rcfp_pkg::RecipWidth-1:0]);
    quo     = prod[28:rcfp_pkg::RecipShift];
    // truncation toward zero: divide the magnitude, then restore the sign
    scaled  = lvl[12] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    sum     = scaled + 13'(rcfp_pkg::WordCenter);
    if (sum < 13'(rcfp_pkg::WordMin)) begin
      word = 11'(rcfp_pkg::WordMin);
    end else if (sum > 13'(rcfp_pkg::WordMax)) begin
      word = 11'(rcfp_pkg::WordMax);
    end else begin
      word = sum[10:0];
    end
    sw_bit = (lvl >= 13'(rcfp_pkg::SwitchLevel));
  end

  // ---- Bit packing ----
  logic [4:0]  ch;
  logic        first_ch, final_ch, wide;
  logic [6:0]  base_bits;
  logic [2:0]  base_cnt;
  logic [17:0] acc;
  logic [4:0]  total;
  logic [1:0]  nfull;
  logic [7:0]  pay [3];

  always_comb begin
    ch        = (chan_q >= 5'(rcfp_pkg::ChannelCount)) ? 5'd0 : chan_q;
    first_ch  = (ch == 5'd0);
    final_ch  = (ch == 5'(rcfp_pkg::ChannelCount - 1));
    wide      = (ch < 5'(rcfp_pkg::WideChannels));
    base_bits = first_ch ? 7'd0 : pend_bits_q;
    base_cnt  = first_ch ? 3'd0 : pend_cnt_q;
    acc       = {11'd0, base_bits}
              | ((wide ? {7'd0, word} : {17'd0, sw_bit}) << base_cnt);
    total     = {2'b00, base_cnt} + (wide ? 5'(rcfp_pkg::WordWidth) : 5'd1);
    nfull     = total[4:3];
    pay[0]    = acc[7:0];
    pay[1]    = acc[15:8];
    pay[2]    = {6'd0, acc[17:16]};
  end

  // Next buffer and frame state.
  always_comb begin
    buf_d       = buf_q;
    rem_d       = rem_q;
    last_d      = last_q;
    chan_d      = chan_q;
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    if (load) begin
      if (first_ch) begin
        buf_d[0] = sync_one_q;
        buf_d[1] = sync_two_q;
        buf_d[2] = marker_q;
        buf_d[3] = pay[0];
        rem_d    = 3'(rcfp_pkg::HeaderBytes) + {1'b0, nfull};
      end else begin
        buf_d[0] = pay[0];
        buf_d[1] = pay[1];
        buf_d[2] = pay[2];
        // the final byte is the partial one sitting after the full bytes
        rem_d    = {1'b0, nfull} + {2'b00, final_ch};
      end
      last_d = final_ch;
      if (final_ch) begin
        chan_d      = 5'd0;
        pend_bits_d = 7'd0;
        pend_cnt_d  = 3'd0;
      end else begin
        chan_d      = ch + 5'd1;
        pend_bits_d = pay[nfull][6:0];
        pend_cnt_d  = total[2:0];
      end
    end else if (out_fire) begin
      for (int i = 0; i < rcfp_pkg::MaxResults - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      rem_d = rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      last_q      <= 1'b0;
      chan_q      <= '0;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else begin
      rem_q       <= rem_d;
      last_q      <= last_d;
      chan_q      <= chan_d;
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

// ----- hw/rtl/rcfp_checker.sv -----
// Port-level checks of the RC channel frame packer, bound to the top level.
module rcfp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] frame_byte_o,
  input logic       last_byte_o
);

  // A stalled byte holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_byte_o)
                                    && $stable(last_byte_o))
    else $error("output byte changed while stalled");

  // Reset clears the output: no byte is offered just after reset is sampled low.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

  // With no byte waiting, the input side is never blocked.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output buffer");

  // The end-of-frame flag marks one byte, never two in a row.
  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_byte_o |=> !(out_valid_o && last_byte_o))
    else $error("end-of-frame flag on consecutive bytes");

endmodule

bind rc_channel_frame_packer_top rcfp_checker u_rcfp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .frame_byte_o (frame_byte_o),
  .last_byte_o  (last_byte_o)
);

// ----- dv/rc_channel_frame_packer_top_tb.sv -----
// Self-checking testbench for rc_channel_frame_packer_top: directed and random frames, scoreboarded.
module rc_channel_frame_packer_top_tb;

  // Frame layout and scaling, taken from the block description.
  localparam int FrameChannels = 18;
  localparam int WordChannels  = 16;
  localparam int WordBits      = 11;
  localparam int MidScale      = 1024;
  localparam int ScaleLow      = 1;
  localparam int ScaleHigh     = 2047;
  localparam int SwitchOnLevel = 512;   // v + 1024 >= 1536

  // Index 3 is not a register; writes to it must be ignored.
  localparam logic [1:0] RegSpare = 2'd3;

  localparam int RandomItems  = 400;
  localparam int SettleCycles = 12;     // input reg + pack cycle + 4-deep byte buffer
  localparam int CycleLimit   = 500000;

  typedef struct packed {
    logic [7:0] octet;
    logic       is_last;
  } frame_byte_t;

  logic clk;
  logic rst_n = 1'b0;

  logic               cfg_valid_r = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index_r = '0;
  logic [7:0]         cfg_data_r  = '0;
  logic               in_valid_r  = 1'b0;
  logic               in_ready;
  logic signed [11:0] channel_value_r = '0;
  logic signed [9:0]  center_offset_r = '0;
  logic               out_valid;
  logic               out_ready_r = 1'b0;
  logic [7:0]         frame_byte;
  logic               last_byte;

  // Bytes the frame packer owes us, oldest first.
  frame_byte_t expected_bytes_q[$];

  // Shadow of the header registers and of the packing state.
  logic [7:0]  hdr_sync_one = '0;
  logic [7:0]  hdr_sync_two = '0;
  logic [7:0]  hdr_marker   = '0;
  int unsigned chan_idx     = 0;
  logic [6:0]  carry_bits   = '0;
  int unsigned carry_cnt    = 0;

  int unsigned mismatches = 0;
  int unsigned bytes_seen = 0;
  int          send_calm  = 0;
  int          recv_calm  = 0;

  // Directed frame: clamp corners, truncation toward zero, doubled offset,
  // the switch threshold and one below it on the two switch channels.
  int directed_vals [FrameChannels] = '{
    -2048, 2047, 0, -1, -1228, -1229, 1228, 1227, 1229,
    -2048, 2047, 1024, -1024, 1024, 0, 0, 512, 511
  };
  int directed_offs [FrameChannels] = '{
    -512, 511, 0, 0, 0, 0, 0, 0, 0,
    511, -512, -512, 0, 0, 511, -512, 0, 0
  };

  // Levels right at the clamp knees, zero and the switch threshold.
  int knee_levels [10] = '{-1230, -1229, -1228, -1, 0, 1, 511, 512, 1228, 1229};
  int value_corners [4] = '{-2048, 2047, 0, -1};
  int offset_corners [4] = '{-512, 511, 0, -1};

  rc_channel_frame_packer_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid_r),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index_r),
    .cfg_data_i      (cfg_data_r),
    .in_valid_i      (in_valid_r),
    .in_ready_o      (in_ready),
    .channel_value_i (channel_value_r),
    .center_offset_i (center_offset_r),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready_r),
    .frame_byte_o    (frame_byte),
    .last_byte_o     (last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle cycles before the next request; now and then a calm stretch with none.
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at byte %0d: %s", bytes_seen, what);
  endtask

  task automatic queue_byte(input logic [7:0] octet, input logic is_last);
    frame_byte_t b;
    b.octet   = octet;
    b.is_last = is_last;
    expected_bytes_q.push_back(b);
  endtask

  // Scale or threshold one channel, pack it LSB first and queue every
  // byte it completes; channel 0 is preceded by the header.
  task automatic pack_channel(input logic signed [11:0] val, input logic signed [9:0] off);
    int          level;
    int          scaled;
    int unsigned word;
    int unsigned nbits;
    int unsigned acc;
    int unsigned total;
    level = int'(val) + 2 * int'(off);
    if (chan_idx == 0) begin
      carry_bits = '0;
      carry_cnt  = 0;
      queue_byte(hdr_sync_one, 1'b0);
      queue_byte(hdr_sync_two, 1'b0);
      queue_byte(hdr_marker, 1'b0);
    end
    if (chan_idx < WordChannels) begin
      scaled = (level * 5) / 6 + MidScale;   // int division truncates toward zero
      if (scaled < ScaleLow)  scaled = ScaleLow;
      if (scaled > ScaleHigh) scaled = ScaleHigh;
      word  = scaled;
      nbits = WordBits;
    end else begin
      word  = (level >= SwitchOnLevel) ? 1 : 0;
      nbits = 1;
    end
    acc   = int'(carry_bits) | (word << carry_cnt);
    total = carry_cnt + nbits;
    while (total >= 8) begin
      queue_byte(acc[7:0], 1'b0);
      acc   = acc >> 8;
      total = total - 8;
    end
    if (chan_idx == FrameChannels - 1) begin
      // frame wrap: flush the padded tail byte
      queue_byte(acc[7:0], 1'b1);
      carry_bits = '0;
      carry_cnt  = 0;
      chan_idx   = 0;
    end else begin
      carry_bits = acc[6:0];
      carry_cnt  = total;
      chan_idx++;
    end
  endtask

  // One channel request. Valid stays up across back-to-back requests; the
  // caller drops it after the last one of a phase.
  task automatic send_channel(input logic signed [11:0] val, input logic signed [9:0] off);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid_r <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_r      <= 1'b1;
    channel_value_r <= val;
    center_offset_r <= off;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    pack_channel(val, off);
  endtask

  // Drop valid, then wait until every owed byte is out and the pipe is quiet.
  task automatic finish_phase();
    in_valid_r <= 1'b0;
    while (expected_bytes_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write the three header registers plus a junk write to the spare index.
  task automatic load_header(input logic [7:0] b_one, input logic [7:0] b_two,
                             input logic [7:0] b_mark);
    logic [1:0] idx_list  [4];
    logic [7:0] data_list [4];
    idx_list  = '{rcfp_pkg::RegSyncOne, rcfp_pkg::RegSyncTwo, rcfp_pkg::RegFrameMark,
                  RegSpare};
    data_list = '{b_one, b_two, b_mark, 8'($urandom)};
    cfg_valid_r <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index_r <= idx_list[i];
      cfg_data_r  <= data_list[i];
      @(posedge clk);
      while (cfg_ready !== 1'b1) @(posedge clk);
      case (idx_list[i])
        rcfp_pkg::RegSyncOne:   hdr_sync_one = data_list[i];
        rcfp_pkg::RegSyncTwo:   hdr_sync_two = data_list[i];
        rcfp_pkg::RegFrameMark: hdr_marker   = data_list[i];
        default: ;
      endcase
    end
    cfg_valid_r <= 1'b0;
  endtask

  task automatic draw_channel(output logic signed [11:0] val, output logic signed [9:0] off);
    int lvl;
    int o;
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        val = 12'($urandom);
        off = 10'($urandom);
      end
      3, 4: begin
        // around nominal stick travel
        o   = int'($urandom_range(0, 40)) - 20;
        lvl = int'($urandom_range(0, 2048)) - 1024;
        val = 12'(lvl);
        off = 10'(o);
      end
      5: begin
        o   = int'($urandom_range(0, 200)) - 100;
        lvl = knee_levels[$urandom_range(0, 9)];
        val = 12'(lvl - 2 * o);
        off = 10'(o);
      end
      default: begin
        val = 12'(value_corners[$urandom_range(0, 3)]);
        off = 10'(offset_corners[$urandom_range(0, 3)]);
      end
    endcase
  endtask

  // Full frame with the reset header (all zero) and directed corner values.
  task automatic test_default_header();
    for (int i = 0; i < FrameChannels; i++) begin
      send_channel(12'(directed_vals[i]), 10'(directed_offs[i]));
    end
    finish_phase();
  endtask

  // All-ones header, then the start of a frame to see it; offset alone
  // sets the level of channel 0.
  task automatic test_header_registers();
    load_header(8'hFF, 8'hFF, 8'hFF);
    send_channel(12'sd0, 10'sd256);
    send_channel(-12'sd512, -10'sd256);
    send_channel(12'sd100, 10'sd0);
    send_channel(-12'sd100, 10'sd1);
    finish_phase();
  endtask

  // Random frames in phases; a new header is loaded between phases.
  task automatic test_random_frames();
    int                 sent;
    int                 span;
    logic signed [11:0] val;
    logic signed [9:0]  off;
    sent = 0;
    while (sent < RandomItems) begin
      span = $urandom_range(18, 60);
      for (int i = 0; i < span; i++) begin
        draw_channel(val, off);
        send_channel(val, off);
      end
      sent += span;
      finish_phase();
      case ($urandom_range(0, 3))
        0:       load_header(8'h00, 8'h00, 8'h00);
        1:       load_header(8'hFF, 8'hFF, 8'hFF);
        default: load_header(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  // Byte sink: random back-pressure, each accepted byte checked in order.
  initial begin
    int          gap;
    frame_byte_t want;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        out_ready_r <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready_r <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if (expected_bytes_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", frame_byte, last_byte));
      end else begin
        want = expected_bytes_q.pop_front();
        if (frame_byte !== want.octet) begin
          report_mismatch($sformatf("frame_byte expected %02h got %02h",
                                    want.octet, frame_byte));
        end
        if (last_byte !== want.is_last) begin
          report_mismatch($sformatf("last_byte expected %0b got %0b",
                                    want.is_last, last_byte));
        end
      end
      bytes_seen++;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_header();
    test_header_registers();
    test_random_frames();
    if (mismatches == 0 && expected_bytes_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
